// ===== sv/bci_pkg.sv =====
package bci_pkg;

  // field widths
  localparam int COORD_BITS = 16;
  localparam int VALUE_BITS = 16;

  // derived datapath widths
  localparam int DW = COORD_BITS + 1;   // coordinate difference
  localparam int PW = 2 * DW;           // difference product
  localparam int NW = PW + 1;           // den, na, nb
  localparam int CW = NW + 2;           // nc = den - na - nb
  localparam int MW = VALUE_BITS + CW;  // value times numerator
  localparam int SW = MW + 2;           // sum of three such products
  localparam int QB = VALUE_BITS;       // quotient bits resolved by the divider
  localparam int RW = (SW > NW + QB) ? SW : NW + QB;  // divider compare width

  // item state carried through the divider stages
  typedef struct packed {
    logic          outside;
    logic          degenerate;
    logic          qneg;
    logic          ovf;
    logic [NW-1:0] d;
    logic [RW-1:0] rem;
    logic [QB-1:0] q;
  } bci_div_t;

endpackage

// ===== sv/bci_setup.sv =====
module bci_setup
  import bci_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         in_vld,
  input  logic signed [COORD_BITS-1:0] px,
  input  logic signed [COORD_BITS-1:0] py,
  input  logic signed [COORD_BITS-1:0] ax,
  input  logic signed [COORD_BITS-1:0] ay,
  input  logic signed [VALUE_BITS-1:0] av,
  input  logic signed [COORD_BITS-1:0] bx,
  input  logic signed [COORD_BITS-1:0] by,
  input  logic signed [VALUE_BITS-1:0] bv,
  input  logic signed [COORD_BITS-1:0] cx,
  input  logic signed [COORD_BITS-1:0] cy,
  input  logic signed [VALUE_BITS-1:0] cv,
  output logic                         out_vld,
  output bci_div_t                     out_st
);

  logic [4:0] v_r;

  // stage 1: coordinate differences
  logic signed [DW-1:0] e1_r, e2_r, e3_r, e4_r, dac_r, dpx_r, dpy_r;
  logic signed [VALUE_BITS-1:0] av1_r, bv1_r, cv1_r;
  // stage 2: difference products
  logic signed [PW-1:0] pd1_r, pd2_r, pa1_r, pa2_r, pb1_r, pb2_r;
  logic signed [VALUE_BITS-1:0] av2_r, bv2_r, cv2_r;
  // stage 3: edge numerators and area
  logic signed [NW-1:0] den_r, na_r, nb_r;
  logic signed [CW-1:0] nc_r;
  logic signed [VALUE_BITS-1:0] av3_r, bv3_r, cv3_r;
  logic out3_r;
  // stage 4: weighted values
  logic signed [MW-1:0] ma_r, mb_r, mc_r;
  logic dneg4_r, deg4_r, out4_r;
  logic [NW-1:0] d4_r;
  // stage 5: sum magnitude
  bci_div_t st5_r;

  logic signed [NW-1:0] den_nxt, na_nxt, nb_nxt;
  logic signed [CW-1:0] nc_nxt;
  logic signed [SW-1:0] sum_nxt;
  logic                 sneg_nxt;

  always_comb begin
    den_nxt = NW'(pd1_r) + NW'(pd2_r);
    na_nxt  = NW'(pa1_r) + NW'(pa2_r);
    nb_nxt  = NW'(pb1_r) + NW'(pb2_r);
    nc_nxt  = CW'(den_nxt) - CW'(na_nxt) - CW'(nb_nxt);
    sum_nxt = SW'(ma_r) + SW'(mb_r) + SW'(mc_r);
    sneg_nxt = sum_nxt[SW-1];
  end

  // valid bits follow the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[3:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e1_r  <= DW'(by) - DW'(cy);
      e2_r  <= DW'(cx) - DW'(bx);
      e3_r  <= DW'(cy) - DW'(ay);
      e4_r  <= DW'(ax) - DW'(cx);
      dac_r <= DW'(ay) - DW'(cy);
      dpx_r <= DW'(px) - DW'(cx);
      dpy_r <= DW'(py) - DW'(cy);
      av1_r <= av;
      bv1_r <= bv;
      cv1_r <= cv;

      pd1_r <= PW'(e1_r) * PW'(e4_r);
      pd2_r <= PW'(e2_r) * PW'(dac_r);
      pa1_r <= PW'(e1_r) * PW'(dpx_r);
      pa2_r <= PW'(e2_r) * PW'(dpy_r);
      pb1_r <= PW'(e3_r) * PW'(dpx_r);
      pb2_r <= PW'(e4_r) * PW'(dpy_r);
      av2_r <= av1_r;
      bv2_r <= bv1_r;
      cv2_r <= cv1_r;

      den_r <= den_nxt;
      na_r  <= na_nxt;
      nb_r  <= nb_nxt;
      nc_r  <= nc_nxt;
      av3_r <= av2_r;
      bv3_r <= bv2_r;
      cv3_r <= cv2_r;
      // a nonzero numerator whose sign opposes the area
      out3_r <= ((na_nxt != '0) && (na_nxt[NW-1] != den_nxt[NW-1])) ||
                ((nb_nxt != '0) && (nb_nxt[NW-1] != den_nxt[NW-1])) ||
                ((nc_nxt != '0) && (nc_nxt[CW-1] != den_nxt[NW-1]));

      ma_r    <= MW'(av3_r) * MW'(na_r);
      mb_r    <= MW'(bv3_r) * MW'(nb_r);
      mc_r    <= MW'(cv3_r) * MW'(nc_r);
      dneg4_r <= den_r[NW-1];
      deg4_r  <= (den_r == '0);
      out4_r  <= out3_r && (den_r != '0);
      d4_r    <= den_r[NW-1] ? NW'(-den_r) : NW'(den_r);

      st5_r.outside    <= out4_r;
      st5_r.degenerate <= deg4_r;
      st5_r.qneg       <= sneg_nxt ^ dneg4_r;
      st5_r.ovf        <= 1'b0;
      st5_r.d          <= d4_r;
      st5_r.rem        <= sneg_nxt ? RW'(unsigned'(-sum_nxt)) : RW'(unsigned'(sum_nxt));
      st5_r.q          <= '0;
    end
  end

  assign out_vld = v_r[4];
  assign out_st  = st5_r;

endmodule

// ===== sv/bci_div.sv =====
module bci_div
  import bci_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     adv,
  input  logic     in_vld,
  input  bci_div_t in_st,
  output logic     out_vld,
  output bci_div_t out_st
);

  bci_div_t    st_r   [0:QB];
  bci_div_t    st_nxt [0:QB];
  logic [QB:0] v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[QB-1:0], in_vld};
    end
  end

  // overflow check first: quotient would need more than QB bits;
  // then one restoring step per stage, most significant quotient bit first
  always_comb begin
    logic [RW-1:0] dsh;
    st_nxt[0]     = in_st;
    st_nxt[0].ovf = in_st.rem >= (RW'(in_st.d) << QB);
    for (int k = 1; k <= QB; k++) begin
      dsh       = RW'(st_r[k-1].d) << (QB - k);
      st_nxt[k] = st_r[k-1];
      if (st_r[k-1].rem >= dsh) begin
        st_nxt[k].rem        = st_r[k-1].rem - dsh;
        st_nxt[k].q[QB - k]  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k <= QB; k++) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  assign out_vld = v_r[QB];
  assign out_st  = st_r[QB];

endmodule

// ===== sv/barycentric_interpolate_2d.sv =====
// channel | ports                                         | handshake
// input   | in_point_*, in_vert_{a,b,c}_{x,y,value}      | in_valid / in_ready
// result  | out_interp_value, out_outside, out_degenerate | out_valid / out_ready
//
// One item per cycle unless a result is stalled; QB + 7 register stages, and the
// restoring divider among them resolves one quotient bit per stage.
// Synchronous active-low reset clears all valid bits; payload is not reset.
// A stalled result freezes the whole pipeline; in_ready falls only then.
module barycentric_interpolate_2d
  import bci_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_point_x,
  input  logic signed [COORD_BITS-1:0] in_point_y,
  input  logic signed [COORD_BITS-1:0] in_vert_a_x,
  input  logic signed [COORD_BITS-1:0] in_vert_a_y,
  input  logic signed [VALUE_BITS-1:0] in_vert_a_value,
  input  logic signed [COORD_BITS-1:0] in_vert_b_x,
  input  logic signed [COORD_BITS-1:0] in_vert_b_y,
  input  logic signed [VALUE_BITS-1:0] in_vert_b_value,
  input  logic signed [COORD_BITS-1:0] in_vert_c_x,
  input  logic signed [COORD_BITS-1:0] in_vert_c_y,
  input  logic signed [VALUE_BITS-1:0] in_vert_c_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [VALUE_BITS-1:0] out_interp_value,
  output logic                         out_outside,
  output logic                         out_degenerate
);

  logic     adv;
  logic     s_vld, d_vld;
  bci_div_t s_st, d_st;

  logic                         valid_r;
  logic signed [VALUE_BITS-1:0] value_r, value_nxt;
  logic                         outside_r, degen_r;

  assign adv      = !valid_r || out_ready;
  assign in_ready = adv;

  bci_setup u_setup (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_vld(in_valid && in_ready),
    .px(in_point_x), .py(in_point_y),
    .ax(in_vert_a_x), .ay(in_vert_a_y), .av(in_vert_a_value),
    .bx(in_vert_b_x), .by(in_vert_b_y), .bv(in_vert_b_value),
    .cx(in_vert_c_x), .cy(in_vert_c_y), .cv(in_vert_c_value),
    .out_vld(s_vld), .out_st(s_st)
  );

  bci_div u_div (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_vld(s_vld), .in_st(s_st),
    .out_vld(d_vld), .out_st(d_st)
  );

  // sign and saturation, and zero for degenerate items
  always_comb begin
    if (d_st.degenerate) begin
      value_nxt = '0;
    end else if (d_st.qneg) begin
      value_nxt = (d_st.ovf || d_st.q[QB-1]) ? {1'b1, {(VALUE_BITS-1){1'b0}}}
                                             : VALUE_BITS'(-d_st.q);
    end else begin
      value_nxt = (d_st.ovf || d_st.q[QB-1]) ? {1'b0, {(VALUE_BITS-1){1'b1}}}
                                             : VALUE_BITS'(d_st.q);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      value_r   <= value_nxt;
      outside_r <= d_st.outside;
      degen_r   <= d_st.degenerate;
    end
  end

  assign out_valid        = valid_r;
  assign out_interp_value = value_r;
  assign out_outside      = outside_r;
  assign out_degenerate   = degen_r;

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && degen_r |-> (value_r == '0) && !outside_r)
    else $error("degenerate item with nonzero value or outside flag");

  a_reset_clear: assert property (@(posedge clk)
    $past(!rst_n) |-> !valid_r)
    else $error("result valid right after reset");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !out_ready |-> !in_ready)
    else $error("item accepted while result stalled");

endmodule
